@@ src/mpt_pkg.sv @@
`default_nettype none

package mpt_pkg;

  // defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 6;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 1'b1;

  localparam logic [IDX_W-1:0] CFG_LEFT_RST  = 6'd0;
  localparam logic [IDX_W-1:0] CFG_RIGHT_RST = 6'd63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FAN_RD,
    ST_FAN_EMIT,
    ST_KEEP,
    ST_POP_RD,
    ST_POP_DIFF,
    ST_POP_MUL,
    ST_POP_CMP,
    ST_FLUSH,
    ST_PUSH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic cur_load;      // latch incoming vertex
    logic keep_load;     // save stack top before a fan
    logic rd_issue;      // read stack entry below the top
    logic diff_load;     // capture below entry, register differences
    logic mul_load;      // register cross products
    logic fan_step;      // top <= entry read, count - 1
    logic pop_step;      // pending <= (top, below), top <= below, count - 1
    logic keep_write;    // stack[0] <= kept top, count = 1
    logic push;          // store current vertex unless full
    logic clear;         // count = 0
    logic out_load;      // load output register
    logic out_sel_pend;  // output from pending triangle
    logic out_last;      // run-end mark of loaded triangle
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic cnt_gt1;
    logic cnt_is2;
    logic cur_final;
    logic chain_diff;
    logic pop_ok;
  } sts_t;

  function automatic logic chain_of(logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                                    logic [IDX_W-1:0] i);
    return ((l < i) ^ (r < i)) ^ (l < r);
  endfunction

endpackage

`default_nettype wire

@@ src/mpt_ram.sv @@
`default_nettype none

module mpt_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/mpt_datapath.sv @@
`default_nettype none

module mpt_datapath #(
  parameter int MAX_POINTS = mpt_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mpt_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic [COORD_BITS-1:0]          in_x_i,
  input  wire logic [COORD_BITS-1:0]          in_y_i,
  input  wire logic [mpt_pkg::IDX_W-1:0]      in_idx_i,
  input  wire logic                           in_final_i,
  input  wire mpt_pkg::cmd_t                  cmd_i,
  output mpt_pkg::sts_t                       sts_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [COORD_BITS-1:0]               out_ax_o,
  output logic [COORD_BITS-1:0]               out_ay_o,
  output logic [COORD_BITS-1:0]               out_bx_o,
  output logic [COORD_BITS-1:0]               out_by_o,
  output logic [COORD_BITS-1:0]               out_cx_o,
  output logic [COORD_BITS-1:0]               out_cy_o,
  output logic                                out_last_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int VW = 2 * COORD_BITS + mpt_pkg::IDX_W;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam logic [AW-1:0] CNT_MAX = AW'(MAX_POINTS - 1);

  // vertex word: {idx, y, x}
  logic [VW-1:0] cur_v, top_q, keep_q, below_q, pend_top_q, pend_below_q, rd_data;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [mpt_pkg::IDX_W-1:0]    cur_idx_q;
  logic                         cur_final_q;
  logic [mpt_pkg::IDX_W-1:0]    left_q, right_q;
  logic [AW-1:0]                cnt_q, cnt_d, rd_addr, wr_addr;
  logic [VW-1:0]                wr_data;
  logic                         wr_en;

  logic signed [COORD_BITS-1:0] top_x, top_y, bel_x, bel_y;
  logic signed [DW-1:0]         ux_q, uy_q, vx_q, vy_q;
  logic signed [PW-1:0]         p1_q, p2_q;
  logic [VW-1:0]                out_b, out_c;
  logic                         out_valid_q;

  assign cur_v = {cur_idx_q, cur_y_q, cur_x_q};
  assign top_x = top_q[COORD_BITS-1:0];
  assign top_y = top_q[2*COORD_BITS-1:COORD_BITS];
  assign bel_x = rd_data[COORD_BITS-1:0];
  assign bel_y = rd_data[2*COORD_BITS-1:COORD_BITS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= mpt_pkg::CFG_LEFT_RST;
      right_q <= mpt_pkg::CFG_RIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpt_pkg::CFG_LEFT:  left_q  <= cfg_data_i;
        mpt_pkg::CFG_RIGHT: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stack memory
  assign rd_addr = cnt_q - AW'(2);
  assign wr_en   = cmd_i.keep_write || (cmd_i.push && cnt_q != CNT_MAX);
  assign wr_addr = cmd_i.keep_write ? '0 : cnt_q;
  assign wr_data = cmd_i.keep_write ? keep_q : cur_v;

  mpt_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_POINTS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // stack count
  always_comb begin
    priority if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.keep_write) begin
      cnt_d = AW'(1);
    end else if (cmd_i.fan_step || cmd_i.pop_step) begin
      cnt_d = cnt_q - AW'(1);
    end else if (cmd_i.push && cnt_q != CNT_MAX) begin
      cnt_d = cnt_q + AW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // vertex registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_x_q     <= in_x_i;
      cur_y_q     <= in_y_i;
      cur_idx_q   <= in_idx_i;
      cur_final_q <= in_final_i;
    end
    if (cmd_i.keep_load) begin
      keep_q <= top_q;
    end
    priority if (cmd_i.keep_write) begin
      top_q <= keep_q;
    end else if (cmd_i.fan_step) begin
      top_q <= rd_data;
    end else if (cmd_i.pop_step) begin
      top_q <= below_q;
    end else if (cmd_i.push && cnt_q != CNT_MAX) begin
      top_q <= cur_v;
    end else begin
      top_q <= top_q;
    end
    if (cmd_i.pop_step) begin
      pend_top_q   <= top_q;
      pend_below_q <= below_q;
    end
  end

  // convexity test: u = cur - top, v = below - top, compare ux*vy against uy*vx
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_load) begin
      below_q <= rd_data;
      ux_q    <= DW'(cur_x_q) - DW'(top_x);
      uy_q    <= DW'(cur_y_q) - DW'(top_y);
      vx_q    <= DW'(bel_x) - DW'(top_x);
      vy_q    <= DW'(bel_y) - DW'(top_y);
    end
    if (cmd_i.mul_load) begin
      p1_q <= ux_q * vy_q;
      p2_q <= uy_q * vx_q;
    end
  end

  // output register
  assign out_b = cmd_i.out_sel_pend ? pend_top_q   : top_q;
  assign out_c = cmd_i.out_sel_pend ? pend_below_q : rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ax_o   <= cur_x_q;
      out_ay_o   <= cur_y_q;
      out_bx_o   <= out_b[COORD_BITS-1:0];
      out_by_o   <= out_b[2*COORD_BITS-1:COORD_BITS];
      out_cx_o   <= out_c[COORD_BITS-1:0];
      out_cy_o   <= out_c[2*COORD_BITS-1:COORD_BITS];
      out_last_o <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.cnt_zero   = cnt_q == '0;
  assign sts_o.cnt_gt1    = cnt_q > AW'(1);
  assign sts_o.cnt_is2    = cnt_q == AW'(2);
  assign sts_o.cur_final  = cur_final_q;
  assign sts_o.chain_diff =
    mpt_pkg::chain_of(left_q, right_q, cur_idx_q) !=
    mpt_pkg::chain_of(left_q, right_q, top_q[VW-1:2*COORD_BITS]);
  assign sts_o.pop_ok     =
    (p1_q > p2_q) ^ mpt_pkg::chain_of(left_q, right_q, cur_idx_q);

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");

  a_step_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fan_step || cmd_i.pop_step) |-> cnt_q >= AW'(2))
    else $error("stack step with fewer than two entries");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> cnt_q >= AW'(2))
    else $error("stack read below bottom");

endmodule

`default_nettype wire

@@ src/mpt_ctrl.sv @@
`default_nettype none

module mpt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mpt_pkg::sts_t  sts_i,
  output mpt_pkg::cmd_t       cmd_o
);

  mpt_pkg::state_e state_q, state_d;
  logic            pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpt_pkg::ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mpt_pkg::ST_DISPATCH;
      end
      mpt_pkg::ST_DISPATCH: begin
        priority if (sts_i.cur_final) begin
          state_d = sts_i.cnt_gt1 ? mpt_pkg::ST_FAN_RD : mpt_pkg::ST_IDLE;
        end else if (sts_i.cnt_zero) begin
          state_d = mpt_pkg::ST_PUSH;
        end else if (sts_i.chain_diff) begin
          state_d = sts_i.cnt_gt1 ? mpt_pkg::ST_FAN_RD : mpt_pkg::ST_PUSH;
        end else begin
          state_d = sts_i.cnt_gt1 ? mpt_pkg::ST_POP_RD : mpt_pkg::ST_PUSH;
        end
      end
      mpt_pkg::ST_FAN_RD: state_d = mpt_pkg::ST_FAN_EMIT;
      mpt_pkg::ST_FAN_EMIT: begin
        if (sts_i.out_free) begin
          if (!sts_i.cnt_is2) begin
            state_d = mpt_pkg::ST_FAN_RD;
          end else begin
            state_d = sts_i.cur_final ? mpt_pkg::ST_IDLE : mpt_pkg::ST_KEEP;
          end
        end
      end
      mpt_pkg::ST_KEEP:     state_d = mpt_pkg::ST_PUSH;
      mpt_pkg::ST_POP_RD:   state_d = mpt_pkg::ST_POP_DIFF;
      mpt_pkg::ST_POP_DIFF: state_d = mpt_pkg::ST_POP_MUL;
      mpt_pkg::ST_POP_MUL:  state_d = mpt_pkg::ST_POP_CMP;
      mpt_pkg::ST_POP_CMP: begin
        if (!sts_i.pop_ok) begin
          state_d = mpt_pkg::ST_FLUSH;
        end else if (!pend_q || sts_i.out_free) begin
          state_d = sts_i.cnt_is2 ? mpt_pkg::ST_FLUSH : mpt_pkg::ST_POP_RD;
        end
      end
      mpt_pkg::ST_FLUSH: begin
        if (!pend_q || sts_i.out_free) state_d = mpt_pkg::ST_PUSH;
      end
      mpt_pkg::ST_PUSH: state_d = mpt_pkg::ST_IDLE;
      default: state_d = mpt_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      mpt_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.cur_load  = in_valid_i;
      end
      mpt_pkg::ST_DISPATCH: begin
        if (sts_i.cur_final) begin
          cmd_o.clear = !sts_i.cnt_gt1;
        end else if (!sts_i.cnt_zero && sts_i.chain_diff) begin
          cmd_o.keep_load = 1'b1;
        end
      end
      mpt_pkg::ST_FAN_RD: cmd_o.rd_issue = 1'b1;
      mpt_pkg::ST_FAN_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = sts_i.cnt_is2;
          cmd_o.fan_step = 1'b1;
          cmd_o.clear    = sts_i.cnt_is2 && sts_i.cur_final;
        end
      end
      mpt_pkg::ST_KEEP:     cmd_o.keep_write = 1'b1;
      mpt_pkg::ST_POP_RD:   cmd_o.rd_issue   = 1'b1;
      mpt_pkg::ST_POP_DIFF: cmd_o.diff_load  = 1'b1;
      mpt_pkg::ST_POP_MUL:  cmd_o.mul_load   = 1'b1;
      mpt_pkg::ST_POP_CMP: begin
        // a popped triangle waits until the next test says whether it ends the run
        if (sts_i.pop_ok && (!pend_q || sts_i.out_free)) begin
          cmd_o.out_load     = pend_q;
          cmd_o.out_sel_pend = 1'b1;
          cmd_o.pop_step     = 1'b1;
          pend_d             = 1'b1;
        end
      end
      mpt_pkg::ST_FLUSH: begin
        if (pend_q && sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel_pend = 1'b1;
          cmd_o.out_last     = 1'b1;
          pend_d             = 1'b0;
        end
      end
      mpt_pkg::ST_PUSH: cmd_o.push = 1'b1;
      default: ;
    endcase
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpt_pkg::ST_IDLE |-> !pend_q)
    else $error("pending triangle lost at end of vertex");

endmodule

`default_nettype wire

@@ src/monotone_polygon_triangulator.sv @@
`default_nettype none

// Channel   Dir  Fields (tdata low bit up)                     tlast
// s_axis    in   vert_x, vert_y, vert_index                    is_final
// m_axis    out  tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy run_end
// cfg       in   we, index (0 left_vertex_index, 1 right_vertex_index), data
//
// One vertex at a time: accept, dispatch, then push. A pop on the same chain
// steps through stack read, differences, products and compare; a fan triangle
// steps through stack read and emit. The stack memory has a single registered
// read port. Reset clears the stack count and output valid and sets the
// configuration to its defaults; the stack memory itself needs no clearing.
// A stalled m_axis holds the sequencer at the emit, compare or flush step;
// s_axis is taken only between vertices.

module monotone_polygon_triangulator #(
  parameter int MAX_POINTS = mpt_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF,
  localparam int IN_DW  = ((2 * COORD_BITS + mpt_pkg::IDX_W + 7) / 8) * 8,
  localparam int OUT_DW = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mpt_pkg::CFG_W-1:0]     cfg_data_i,
  // vertex stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [IN_DW-1:0]              s_axis_tdata,  // vert_x, vert_y, vert_index
  input  wire logic                          s_axis_tlast,  // is_final
  // triangle stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [OUT_DW-1:0]                  m_axis_tdata,  // ax, ay, bx, by, cx, cy
  output logic                               m_axis_tlast   // run_end
);

  mpt_pkg::cmd_t cmd;
  mpt_pkg::sts_t sts;

  logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

  mpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mpt_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_x_i     (s_axis_tdata[COORD_BITS-1:0]),
    .in_y_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_idx_i   (s_axis_tdata[2*COORD_BITS+mpt_pkg::IDX_W-1:2*COORD_BITS]),
    .in_final_i (s_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ax_o   (ax),
    .out_ay_o   (ay),
    .out_bx_o   (bx),
    .out_by_o   (by),
    .out_cx_o   (cx),
    .out_cy_o   (cy),
    .out_last_o (m_axis_tlast)
  );

  // zero fill up to a byte boundary
  assign m_axis_tdata = OUT_DW'({cy, cx, by, bx, ay, ax});

endmodule

`default_nettype wire

@@ tb/tb_monotone_polygon_triangulator.sv @@
`timescale 1ns / 1ps

module tb_monotone_polygon_triangulator;

  localparam int MAX_PTS   = mpt_pkg::MAX_POINTS_DEF;
  localparam int CW        = mpt_pkg::COORD_BITS_DEF;
  localparam int IW        = mpt_pkg::IDX_W;
  localparam int IN_DW     = ((2 * CW + mpt_pkg::IDX_W + 7) / 8) * 8;
  localparam int OUT_DW    = ((6 * CW + 7) / 8) * 8;
  // worst internal work after the last triangle: pop checks plus the push
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int ITEM_TARGET   = 210;

  typedef struct packed {
    logic [CW-1:0]            x;
    logic [CW-1:0]            y;
    logic [mpt_pkg::IDX_W-1:0] idx;
  } vertex_t;

  // coord[0] = ax ... coord[5] = cy, same order as m_axis_tdata
  typedef struct packed {
    logic                 run_end;
    logic [5:0][CW-1:0]   coord;
  } triangle_t;

  // Shadow of the block: stack, chain bounds, and the triangles still owed.
  class triangle_scoreboard;
    vertex_t   chain_stack [MAX_PTS];
    int        depth;
    logic [mpt_pkg::IDX_W-1:0] left_idx;
    logic [mpt_pkg::IDX_W-1:0] right_idx;
    triangle_t triangles_due [$];
    int        errors;
    string     coord_name [6];

    function new();
      depth     = 0;
      left_idx  = mpt_pkg::CFG_LEFT_RST;
      right_idx = mpt_pkg::CFG_RIGHT_RST;
      errors    = 0;
      coord_name = '{"tri_ax", "tri_ay", "tri_bx", "tri_by", "tri_cx", "tri_cy"};
    endfunction

    function bit chain_side(logic [mpt_pkg::IDX_W-1:0] i);
      return ((left_idx < i) ^ (right_idx < i)) ^ (left_idx < right_idx);
    endfunction

    // cross(cur - top, below - top) > 0, exact in 64 bits
    function bit turns_ccw(vertex_t c, vertex_t t, vertex_t b);
      longint ux, uy, vx, vy;
      ux = longint'($signed(c.x)) - longint'($signed(t.x));
      uy = longint'($signed(c.y)) - longint'($signed(t.y));
      vx = longint'($signed(b.x)) - longint'($signed(t.x));
      vy = longint'($signed(b.y)) - longint'($signed(t.y));
      return (ux * vy) > (uy * vx);
    endfunction

    function triangle_t make_tri(vertex_t c, vertex_t t, vertex_t b);
      triangle_t tr;
      tr.coord[0] = c.x;
      tr.coord[1] = c.y;
      tr.coord[2] = t.x;
      tr.coord[3] = t.y;
      tr.coord[4] = b.x;
      tr.coord[5] = b.y;
      tr.run_end  = 1'b0;
      return tr;
    endfunction

    function void push_vertex(vertex_t v);
      // one slot stays unused; a push onto a full stack is lost
      if (depth < MAX_PTS - 1) begin
        chain_stack[depth] = v;
        depth++;
      end
    endfunction

    // accepted vertex: update shadow stack, queue the triangles it causes
    function void note_vertex(vertex_t cur, bit fin);
      triangle_t fresh [$];
      vertex_t   keep;
      bit        cc;
      if (fin) begin
        while (depth > 1) begin
          fresh = {fresh, make_tri(cur, chain_stack[depth-1], chain_stack[depth-2])};
          depth--;
        end
        depth = 0;
      end else if (depth == 0) begin
        push_vertex(cur);
      end else begin
        cc = chain_side(cur.idx);
        if (cc != chain_side(chain_stack[depth-1].idx)) begin
          // chain change: fan everything, old top becomes the new base
          keep = chain_stack[depth-1];
          while (depth > 1) begin
            fresh = {fresh, make_tri(cur, chain_stack[depth-1], chain_stack[depth-2])};
            depth--;
          end
          chain_stack[0] = keep;
          push_vertex(cur);
        end else begin
          while (depth > 1) begin
            if (!(turns_ccw(cur, chain_stack[depth-1], chain_stack[depth-2]) ^ cc))
              break;
            fresh = {fresh, make_tri(cur, chain_stack[depth-1], chain_stack[depth-2])};
            depth--;
          end
          push_vertex(cur);
        end
      end
      if (fresh.size() > 0)
        fresh[fresh.size()-1].run_end = 1'b1;
      triangles_due = {triangles_due, fresh};
    endfunction

    function void check_triangle(logic [OUT_DW-1:0] data, logic last);
      triangle_t want;
      triangle_t got;
      got.coord   = data[6*CW-1:0];
      got.run_end = last;
      if (triangles_due.size() == 0) begin
        $display("%0t ns: unexpected triangle tdata=%h tlast=%0b", $time, data, last);
        errors++;
        return;
      end
      want = triangles_due.pop_front();
      for (int k = 0; k < 6; k++) begin
        if (got.coord[k] !== want.coord[k]) begin
          $display("%0t ns: %s expected %0d got %0d", $time, coord_name[k],
                   $signed(want.coord[k]), $signed(got.coord[k]));
          errors++;
        end
      end
      if (got.run_end !== want.run_end) begin
        $display("%0t ns: run_end expected %0b got %0b", $time, want.run_end, got.run_end);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (triangles_due.size() != 0) begin
        $display("%0t ns: %0d triangles never arrived", $time, triangles_due.size());
        errors += triangles_due.size();
      end
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index_i = mpt_pkg::CFG_LEFT;
  logic [mpt_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [IN_DW-1:0]              s_axis_tdata = '0;   // vert_x, vert_y, vert_index
  logic                          s_axis_tlast = 1'b0; // is_final
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]             m_axis_tdata;        // ax, ay, bx, by, cx, cy
  logic                          m_axis_tlast;        // run_end

  triangle_scoreboard sb;
  int  n_sent = 0;
  int  hold_left = 0;
  bit  quiet = 1'b0;   // no gaps on either side while set

  monotone_polygon_triangulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // -------------------------------------------------------- triangle sink
  // Values read right after the edge are the pre-edge ones, so this sees
  // exactly the transfer that happened at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_triangle(m_axis_tdata, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          hold_left = pick_gap();
      end
    end
  end

  // -------------------------------------------------------- vertex source
  // Leaves tvalid high after the transfer; the next call either drops it
  // for a gap or reloads data in the same step, so one NBA per step.
  task automatic send_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [mpt_pkg::IDX_W-1:0] idx, input logic fin);
    int      gap;
    vertex_t v;
    gap   = pick_gap();
    v.x   = x;
    v.y   = y;
    v.idx = idx;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, y, x};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex(v, fin);
    n_sent++;
  endtask

  // stop sending, wait for every owed triangle, then let the block go idle
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.triangles_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bounds(input logic [mpt_pkg::IDX_W-1:0] lft,
                              input logic [mpt_pkg::IDX_W-1:0] rgt);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mpt_pkg::CFG_LEFT;
    cfg_data_i  <= lft;
    @(posedge clk_i);
    sb.left_idx = lft;
    cfg_index_i <= mpt_pkg::CFG_RIGHT;
    cfg_data_i  <= rgt;
    @(posedge clk_i);
    sb.right_idx = rgt;
    cfg_we_i <= 1'b0;
  endtask

  // x-sorted polygon: first at the left index, last at the right index.
  // Tiny ones sit on a small grid so ties and collinear triples are common.
  // A truncated one never gets its final vertex.
  task automatic send_polygon(input bit truncate);
    int  n, xpos, ystep_max, xstep_max, yval;
    bit  tiny;
    logic [mpt_pkg::IDX_W-1:0] idx;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(3, 10);
    tiny = ($urandom_range(0, 2) == 0);
    if (tiny) begin
      xpos = -4;
      xstep_max = 1;
    end else begin
      xpos = -32768 + int'($urandom_range(0, 20000));
      xstep_max = (32767 - xpos) / n;
    end
    for (int k = 0; k < n; k++) begin
      if (truncate && k == n - 1) break;
      if (k == 0) idx = sb.left_idx;
      else if (k == n - 1) idx = sb.right_idx;
      else idx = IW'($urandom_range(0, 63));
      if (tiny) yval = int'($urandom_range(0, 8)) - 4;
      else yval = int'($urandom_range(0, 65535));
      send_vertex(CW'(xpos), CW'(yval), idx, k == n - 1);
      xpos += int'($urandom_range(0, xstep_max));
    end
  endtask

  // --------------------------------------------------------------- main
  initial begin
    int phase, r, burst;
    logic [mpt_pkg::IDX_W-1:0] lft, rgt;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, under the reset bounds (left 0, right 63): only index 0
    // sits on the other chain.
    send_vertex(CW'(0), CW'(0), IW'(0), 1'b1);                // final on empty stack
    send_vertex(CW'(-32768), CW'(-32768), IW'(0), 1'b0);
    send_vertex(CW'(-100), CW'(5), IW'(63), 1'b1);            // final with a single entry
    send_vertex(CW'(-32768), CW'(0), IW'(0), 1'b0);
    send_vertex(CW'(-30000), CW'(32767), IW'(1), 1'b0);       // chain change, nothing to fan
    send_vertex(CW'(-20000), CW'(0), IW'(2), 1'b0);
    send_vertex(CW'(-10000), CW'(20000), IW'(3), 1'b0);       // same chain, convex pop
    send_vertex(CW'(0), CW'(-300), IW'(0), 1'b0);             // chain change, fan
    send_vertex(CW'(100), CW'(-200), IW'(0), 1'b0);
    send_vertex(CW'(200), CW'(-100), IW'(0), 1'b0);
    send_vertex(CW'(300), CW'(0), IW'(0), 1'b0);
    send_vertex(CW'(32767), CW'(32767), IW'(63), 1'b1);       // fan out and close
    send_vertex(CW'(-5), CW'(-5), IW'(62), 1'b0);
    send_vertex(CW'(-4), CW'(-4), IW'(62), 1'b0);
    send_vertex(CW'(-3), CW'(-3), IW'(61), 1'b0);             // collinear, zero cross product
    send_vertex(CW'(-2), CW'(7), IW'(0), 1'b0);
    send_vertex(CW'(-1), CW'(-32768), IW'(1), 1'b0);
    send_vertex(CW'(32767), CW'(-32768), IW'(63), 1'b1);
    drain_and_settle();

    // Full stack: collinear run on one chain never pops; pushes past the
    // last slot are lost, the final vertex fans the longest possible run.
    write_bounds(mpt_pkg::CFG_LEFT_RST, mpt_pkg::CFG_RIGHT_RST);
    quiet = 1'b1;
    for (int k = 0; k < MAX_PTS + 2; k++)
      send_vertex(CW'(-32000 + k * 900), CW'(30000 - k * 900),
                  IW'($urandom_range(1, 62)), 1'b0);
    send_vertex(CW'(32767), CW'(0), IW'(63), 1'b1);
    drain_and_settle();
    quiet = 1'b0;

    // Random phases, bounds changed only with the block drained and idle.
    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      drain_and_settle();
      case (phase)
        0:       begin lft = 6'd63; rgt = 6'd0;  end
        1:       begin lft = 6'd5;  rgt = 6'd40; end
        2:       begin lft = 6'd40; rgt = 6'd5;  end
        3:       begin lft = 6'd0;  rgt = 6'd0;  end
        4:       begin lft = 6'd63; rgt = 6'd63; end
        default: begin
          lft = IW'($urandom_range(0, 63));
          rgt = IW'($urandom_range(0, 63));
        end
      endcase
      write_bounds(lft, rgt);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (4) begin
        r = $urandom_range(0, 9);
        if (r <= 6) begin
          send_polygon($urandom_range(0, 4) == 0);
        end else if (r <= 8) begin
          // noise: anything the fields allow, unsorted
          burst = $urandom_range(1, 4);
          repeat (burst)
            send_vertex(CW'($urandom_range(0, 65535)), CW'($urandom_range(0, 65535)),
                        IW'($urandom_range(0, 63)), $urandom_range(0, 7) == 0);
        end else begin
          drain_and_settle();   // let every owed triangle out mid-phase
        end
      end
      phase++;
    end

    drain_and_settle();
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
